FILE: design/bpa_pkg.sv
package bpa_pkg;

    localparam int DEF_NUM_PAGES  = 4096;
    localparam int DEF_PAGE_SHIFT = 12;

    localparam int COUNT_W  = 13;
    localparam int FRAME_W  = 36;
    localparam int ADDR_W   = 48;
    localparam int STATUS_W = 2;
    localparam int WORD_W   = 64;
    localparam int BIT_W    = 6;

    // configuration register indexes
    localparam logic REG_TOTAL_PAGES = 1'b0;
    localparam logic REG_BASE_FRAME  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_RUN  = 2'd2;

    // outcome of one word evaluation during a scan
    typedef struct packed {
        logic             hit;
        logic [BIT_W-1:0] hit_bit;
    } scan_res_t;

    // ones on bits lo..hi of a map word
    function automatic logic [WORD_W-1:0] range_mask(input logic [BIT_W-1:0] lo,
                                                     input logic [BIT_W-1:0] hi);
        logic [WORD_W-1:0] lo_part;
        logic [WORD_W-1:0] hi_part;
        lo_part = {WORD_W{1'b1}} << lo;
        hi_part = {WORD_W{1'b1}} >> (6'd63 - hi);
        return lo_part & hi_part;
    endfunction

endpackage

FILE: design/bpa_ram.sv
module bpa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

FILE: design/bpa_word_scan.sv
module bpa_word_scan #(
    parameter int TW = 13
) (
    input  logic [bpa_pkg::WORD_W-1:0] rdata,
    input  logic [bpa_pkg::BIT_W-1:0]  lo_b,
    input  logic [bpa_pkg::BIT_W-1:0]  hi_b,
    input  logic [TW:0]                run_in,
    input  logic [TW-1:0]              need,
    output bpa_pkg::scan_res_t         sres,
    output logic [TW:0]                run_out
);
    import bpa_pkg::*;

    localparam int LEVELS = 6;

    logic [WORD_W-1:0] used_v;
    logic [WORD_W-1:0] has_l  [LEVELS+1];
    logic [BIT_W-1:0]  idx_l  [LEVELS+1][WORD_W];
    logic [TW:0]       run_v  [WORD_W];
    logic [WORD_W-1:0] hit_v;

    // pages outside the pass window act as used
    assign used_v = rdata | ~range_mask(lo_b, hi_b);

    // prefix tree: nearest used page at or below each bit
    always_comb begin
        has_l[0] = used_v;
        for (int i = 0; i < WORD_W; i++) begin
            idx_l[0][i] = BIT_W'(i);
        end
        for (int k = 0; k < LEVELS; k++) begin
            for (int i = 0; i < WORD_W; i++) begin
                if (i >= (1 << k) && !has_l[k][i]) begin
                    has_l[k+1][i] = has_l[k][i - (1 << k)];
                    idx_l[k+1][i] = idx_l[k][i - (1 << k)];
                end else begin
                    has_l[k+1][i] = has_l[k][i];
                    idx_l[k+1][i] = idx_l[k][i];
                end
            end
        end
    end

    // free run length ending at each bit, and the bits that reach the need
    always_comb begin
        for (int i = 0; i < WORD_W; i++) begin
            if (has_l[LEVELS][i]) begin
                run_v[i] = (TW+1)'(BIT_W'(i) - idx_l[LEVELS][i]);
            end else begin
                run_v[i] = run_in + (TW+1)'(i + 1);
            end
            hit_v[i] = run_v[i] >= {1'b0, need};
        end
    end

    // pick the lowest hit
    always_comb begin
        sres.hit     = |hit_v;
        sres.hit_bit = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (hit_v[i]) begin
                sres.hit_bit = BIT_W'(i);
            end
        end
    end

    assign run_out = run_v[WORD_W-1];

endmodule

FILE: design/bitmap_page_allocator.sv
// Sequence: an allocate passes through the check step, a scan of map words and the marking
// of the words in the run; a free passes through the check, the free check and the clearing
// of its words; a rejected request goes from the checks straight to the result. One 64-page
// map word is read per cycle from the map memory while scanning.
// Throughput: one item at a time; the next item is taken as soon as the result is parked.
// Reset: synchronous, active low; the map memory is then cleared one word per cycle,
// over the whole map, before the first item is accepted.
module bitmap_page_allocator #(
    parameter int NUM_PAGES  = bpa_pkg::DEF_NUM_PAGES,
    parameter int PAGE_SHIFT = bpa_pkg::DEF_PAGE_SHIFT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration writes
    input  logic                         cfg_wr_en,
    input  logic                         cfg_index,
    input  logic [bpa_pkg::FRAME_W-1:0]  cfg_wdata,
    // request items
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [63:0]                  s_tdata,   // page_count[12:0], address[60:13]
    input  logic                         s_tuser,   // opcode
    // result items
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [55:0]                  m_tdata    // status[1:0], address_res[49:2]
);
    import bpa_pkg::*;

    localparam int WORDS = (NUM_PAGES + 63) / 64;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PW    = $clog2(NUM_PAGES + 1);
    localparam int TW0   = (COUNT_W > AW + BIT_W) ? COUNT_W : AW + BIT_W;
    localparam int TW    = (TW0 > PW) ? TW0 : PW;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_FCHK  = 7'b0001000,
        S_SCAN  = 7'b0010000,
        S_RANGE = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    logic [COUNT_W-1:0]    tp_reg;
    logic [FRAME_W-1:0]    base_reg;
    logic [TW-1:0]         ss_reg, ss_next;
    logic                  op_reg;
    logic [COUNT_W-1:0]    cnt_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic [AW-1:0]         word_reg, word_next;
    logic                  rdv_reg, rdv_next;
    logic                  pass2_reg, pass2_next;
    logic [TW-1:0]         from_reg, from_next;
    logic [TW-1:0]         to_reg, to_next;
    logic [TW-1:0]         need_reg, need_next;
    logic [TW:0]           run_reg, run_next;
    logic [TW-1:0]         lo_reg, lo_next;
    logic [TW-1:0]         last_reg, last_next;
    logic                  set_reg, set_next;
    logic [ADDR_W-1:0]     start_reg, start_next;
    logic                  bad_reg, bad_next;
    logic [STATUS_W-1:0]   res_st_reg, res_st_next;
    logic [ADDR_W-1:0]     res_addr_reg, res_addr_next;
    logic                  m_tvalid_reg;
    logic [STATUS_W-1:0]   m_st_reg;
    logic [ADDR_W-1:0]     m_addr_reg;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [WORD_W-1:0]     ram_wdata;
    logic [WORD_W-1:0]     ram_rdata;

    logic [TW-1:0]         total;
    logic [TW-1:0]         tp_ext;
    logic [TW-1:0]         to_m1;
    logic [AW-1:0]         from_word, last_word, lo_word, hi_word;
    logic [BIT_W-1:0]      scan_lo_b, scan_hi_b, rng_lo_b, rng_hi_b;
    logic [WORD_W-1:0]     rng_mask;
    scan_res_t             sres;
    logic [TW:0]           run_out;
    logic [TW-1:0]         hit_page, first_page;
    logic [ADDR_W-1:0]     frame;
    logic [ADDR_W:0]       free_end;
    logic                  accept, out_free;

    // managed page count
    assign tp_ext = TW'(tp_reg);
    assign total  = (tp_ext > TW'(NUM_PAGES)) ? TW'(NUM_PAGES) : tp_ext;

    // scan window bounds inside the current word
    assign to_m1     = to_reg - TW'(1);
    assign from_word = from_reg[AW+BIT_W-1:BIT_W];
    assign last_word = to_m1[AW+BIT_W-1:BIT_W];
    assign scan_lo_b = (word_reg == from_word) ? from_reg[BIT_W-1:0] : '0;
    assign scan_hi_b = (word_reg == last_word) ? to_m1[BIT_W-1:0] : 6'd63;

    // mark or clear range bounds inside the current word
    assign lo_word  = lo_reg[AW+BIT_W-1:BIT_W];
    assign hi_word  = last_reg[AW+BIT_W-1:BIT_W];
    assign rng_lo_b = (word_reg == lo_word) ? lo_reg[BIT_W-1:0] : '0;
    assign rng_hi_b = (word_reg == hi_word) ? last_reg[BIT_W-1:0] : 6'd63;
    assign rng_mask = range_mask(rng_lo_b, rng_hi_b);

    assign hit_page   = TW'({word_reg, sres.hit_bit});
    assign first_page = hit_page - need_reg + TW'(1);

    assign frame    = addr_reg >> PAGE_SHIFT;
    assign free_end = {1'b0, start_reg} + (ADDR_W+1)'(cnt_reg);

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, m_addr_reg, m_st_reg};

    bpa_ram #(
        .WIDTH(WORD_W),
        .DEPTH(WORDS)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (word_next),
        .rdata (ram_rdata)
    );

    bpa_word_scan #(
        .TW(TW)
    ) u_scan (
        .rdata   (ram_rdata),
        .lo_b    (scan_lo_b),
        .hi_b    (scan_hi_b),
        .run_in  (run_reg),
        .need    (need_reg),
        .sres    (sres),
        .run_out (run_out)
    );

    // sequencer
    always_comb begin
        state_next    = state_reg;
        ss_next       = ss_reg;
        word_next     = word_reg;
        rdv_next      = rdv_reg;
        pass2_next    = pass2_reg;
        from_next     = from_reg;
        to_next       = to_reg;
        need_next     = need_reg;
        run_next      = run_reg;
        lo_next       = lo_reg;
        last_next     = last_reg;
        set_next      = set_reg;
        start_next    = start_reg;
        bad_next      = bad_reg;
        res_st_next   = res_st_reg;
        res_addr_next = res_addr_reg;
        ram_we        = 1'b0;
        ram_waddr     = word_reg;
        ram_wdata     = '0;

        unique case (state_reg)
            S_CLEAR: begin
                ram_we = 1'b1;
                if (word_reg == AW'(WORDS - 1)) begin
                    state_next = S_IDLE;
                end else begin
                    word_next = word_reg + AW'(1);
                end
            end
            S_IDLE: begin
                rdv_next = 1'b0;
                if (accept) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                res_st_next   = ST_INVALID;
                res_addr_next = '0;
                if (op_reg) begin
                    // free: range start relative to the managed pages
                    start_next = frame - ADDR_W'(base_reg);
                    bad_next   = (frame < ADDR_W'(base_reg)) || (cnt_reg == '0);
                    state_next = S_FCHK;
                end else if (cnt_reg == '0 || TW'(cnt_reg) > total) begin
                    state_next = S_DONE;
                end else begin
                    // open the first pass, or the wrapped pass if it is empty
                    need_next  = TW'(cnt_reg);
                    run_next   = '0;
                    rdv_next   = 1'b1;
                    state_next = S_SCAN;
                    to_next    = total;
                    if (ss_reg < total) begin
                        pass2_next = 1'b0;
                        from_next  = ss_reg;
                        word_next  = ss_reg[AW+BIT_W-1:BIT_W];
                    end else begin
                        pass2_next = 1'b1;
                        from_next  = '0;
                        word_next  = '0;
                    end
                end
            end
            S_FCHK: begin
                if (bad_reg || free_end > (ADDR_W+1)'(total)) begin
                    state_next = S_DONE;
                end else begin
                    res_st_next = ST_OK;
                    lo_next     = start_reg[TW-1:0];
                    last_next   = TW'(free_end - (ADDR_W+1)'(1));
                    set_next    = 1'b0;
                    if (start_reg[TW-1:0] < ss_reg) begin
                        ss_next = start_reg[TW-1:0];
                    end
                    word_next  = start_reg[AW+BIT_W-1:BIT_W];
                    rdv_next   = 1'b1;
                    state_next = S_RANGE;
                end
            end
            S_SCAN: begin
                if (sres.hit) begin
                    res_st_next   = ST_OK;
                    res_addr_next = ADDR_W'((ADDR_W'(base_reg) + ADDR_W'(first_page))
                                            << PAGE_SHIFT);
                    lo_next       = first_page;
                    last_next     = hit_page;
                    ss_next       = hit_page + TW'(1);
                    set_next      = 1'b1;
                    word_next     = first_page[AW+BIT_W-1:BIT_W];
                    state_next    = S_RANGE;
                end else if (word_reg == last_word) begin
                    if (!pass2_reg && ss_reg != '0) begin
                        // wrap: scan from page zero up to the search position
                        pass2_next = 1'b1;
                        from_next  = '0;
                        to_next    = ss_reg;
                        run_next   = '0;
                        word_next  = '0;
                    end else begin
                        res_st_next = ST_NO_RUN;
                        rdv_next    = 1'b0;
                        state_next  = S_DONE;
                    end
                end else begin
                    run_next  = run_out;
                    word_next = word_reg + AW'(1);
                end
            end
            S_RANGE: begin
                // write back the word read last cycle, fetch the next one
                ram_we    = 1'b1;
                ram_wdata = set_reg ? (ram_rdata | rng_mask) : (ram_rdata & ~rng_mask);
                if (word_reg == hi_word) begin
                    rdv_next   = 1'b0;
                    state_next = S_DONE;
                end else begin
                    word_next = word_reg + AW'(1);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            word_reg     <= '0;
            rdv_reg      <= 1'b0;
            ss_reg       <= '0;
            tp_reg       <= COUNT_W'(4096);
            base_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            word_reg  <= word_next;
            rdv_reg   <= rdv_next;
            ss_reg    <= ss_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_TOTAL_PAGES: tp_reg   <= cfg_wdata[COUNT_W-1:0];
                    REG_BASE_FRAME:  base_reg <= cfg_wdata;
                    default:         tp_reg   <= tp_reg;
                endcase
            end
            if (state_reg == S_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        pass2_reg    <= pass2_next;
        from_reg     <= from_next;
        to_reg       <= to_next;
        need_reg     <= need_next;
        run_reg      <= run_next;
        lo_reg       <= lo_next;
        last_reg     <= last_next;
        set_reg      <= set_next;
        start_reg    <= start_next;
        bad_reg      <= bad_next;
        res_st_reg   <= res_st_next;
        res_addr_reg <= res_addr_next;
        if (accept) begin
            op_reg   <= s_tuser;
            cnt_reg  <= s_tdata[12:0];
            addr_reg <= s_tdata[60:13];
        end
        if (state_reg == S_DONE && out_free) begin
            m_st_reg   <= res_st_reg;
            m_addr_reg <= res_addr_reg;
        end
    end

    a_accept_check: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == S_CHECK)
        else $error("accepted item did not enter the check step");

    a_ss_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ss_reg <= TW'(NUM_PAGES))
        else $error("search position beyond the map");

    a_word_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rdv_reg |-> word_reg <= AW'(WORDS - 1))
        else $error("map word address out of range");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_st_reg == ST_OK || m_st_reg == ST_INVALID ||
                          m_st_reg == ST_NO_RUN))
        else $error("undefined result status");

    a_err_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_st_reg != ST_OK) |-> m_addr_reg == '0)
        else $error("error result carries an address");

endmodule

FILE: dv/tb_bitmap_page_allocator.sv
`timescale 1ns / 100ps

module tb_bitmap_page_allocator;
    import bpa_pkg::*;

    localparam int NPAGES   = DEF_NUM_PAGES;
    localparam int PSHIFT   = DEF_PAGE_SHIFT;
    localparam int N_RANDOM = 1630;
    localparam longint CYCLE_LIMIT = 2000000;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   addr;
    } alloc_result_t;

    typedef struct {
        logic               op;
        logic [COUNT_W-1:0] count;
        logic [ADDR_W-1:0]  addr;
        logic               known;
        alloc_result_t      res;
    } req_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic cfg_index = 1'b0;
    logic [FRAME_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [63:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [55:0] m_tdata;

    bitmap_page_allocator DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // shadow allocator state
    logic [NPAGES-1:0]  page_used;
    logic [COUNT_W-1:0] next_fit;
    logic [COUNT_W-1:0] cfg_total;
    logic [FRAME_W-1:0] cfg_base;

    alloc_result_t pending_results[$];
    int  errors = 0;
    int  rx_hold = 0;
    int  n_results = 0;

    function automatic bit find_run(input int from, input int to, input int need,
                                    output int first);
        int run;
        run = 0;
        first = 0;
        for (int p = from; p < to; p++) begin
            if (page_used[p]) begin
                run = 0;
            end else begin
                if (run == 0) first = p;
                run++;
                if (run >= need) return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic alloc_result_t predict_request(input logic op,
                                                      input logic [COUNT_W-1:0] count,
                                                      input logic [ADDR_W-1:0] addr);
        alloc_result_t r;
        int total;
        int first;
        int wrap_end;
        bit found;
        logic [ADDR_W-1:0] frame;
        longint start;
        r.status = ST_INVALID;
        r.addr = '0;
        total = (cfg_total < NPAGES) ? int'(cfg_total) : NPAGES;
        if (op == OP_ALLOC) begin
            if (count == 0 || count > total) return r;
            found = find_run(int'(next_fit), total, int'(count), first);
            if (!found) begin
                wrap_end = (next_fit < total) ? int'(next_fit) : total;
                found = find_run(0, wrap_end, int'(count), first);
            end
            if (!found) begin
                r.status = ST_NO_RUN;
                return r;
            end
            for (int p = first; p < first + count; p++) page_used[p] = 1'b1;
            next_fit = COUNT_W'(first + int'(count));
            r.status = ST_OK;
            r.addr = ADDR_W'(({12'b0, cfg_base} + 48'(first)) << PSHIFT);
        end else begin
            frame = addr >> PSHIFT;
            if (frame < {12'b0, cfg_base} || count == 0) return r;
            start = longint'(frame - {12'b0, cfg_base});
            if (start + count > total) return r;
            for (int p = int'(start); p < int'(start) + count; p++) page_used[p] = 1'b0;
            if (start < next_fit) next_fit = COUNT_W'(start);
            r.status = ST_OK;
        end
        return r;
    endfunction

    // watchdog
    longint cycles = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("bitmap_page_allocator verification failed");
            $finish;
        end
    end

    // result side: random stalls plus an optional long hold-off
    initial begin
        int gap;
        @(posedge aclk);
        while (1) begin
            if (rx_hold > 0) begin
                m_tready <= 1'b0;
                repeat (rx_hold) @(posedge aclk);
                rx_hold = 0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        alloc_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tdata[1:0];
            got.addr = m_tdata[49:2];
            n_results++;
            if (pending_results.size() == 0) begin
                $error("unexpected result status=%0d address_res=%h", got.status, got.addr);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d actual %0d", want.status, got.status);
                    errors++;
                end
                if (got.addr !== want.addr) begin
                    $error("address_res: expected %h actual %h", want.addr, got.addr);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(input logic idx, input logic [FRAME_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_TOTAL_PAGES) cfg_total = val[COUNT_W-1:0];
        else cfg_base = val;
    endtask

    // wait for the block to drain before touching registers
    task automatic drain();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic send_request(input logic op, input logic [COUNT_W-1:0] count,
                                input logic [ADDR_W-1:0] addr, input bit known,
                                input alloc_result_t known_res, input bit gaps);
        alloc_result_t r;
        int gap;
        gap = gaps ? (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5)) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {3'b0, addr, count};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = predict_request(op, count, addr);
        if (known && r !== known_res) begin
            $error("table row disagrees: expected %0d/%h predicted %0d/%h",
                   known_res.status, known_res.addr, r.status, r.addr);
            errors++;
        end
        pending_results.push_back(r);
    endtask

    task automatic idle_input();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [ADDR_W-1:0] page_addr(input int pg);
        return ADDR_W'(({12'b0, cfg_base} + 48'(pg)) << PSHIFT);
    endfunction

    // random request biased toward well-formed alloc and free of in-range pages
    task automatic random_request(input bit gaps);
        logic op;
        logic [COUNT_W-1:0] cnt;
        logic [ADDR_W-1:0] a;
        int total;
        int k;
        int pg;
        alloc_result_t none;
        none = '0;
        total = (cfg_total < NPAGES) ? int'(cfg_total) : NPAGES;
        if (total == 0) total = 1;
        k = $urandom_range(0, 99);
        op = (k < 50) ? OP_ALLOC : OP_FREE;
        if (k < 8) cnt = COUNT_W'($urandom);
        else if (k < 44) cnt = COUNT_W'($urandom_range(1, (total < 16) ? total : 16));
        else if (k < 50) cnt = COUNT_W'($urandom_range(1, total));
        else cnt = COUNT_W'($urandom_range(1, (total < 24) ? total : 24));
        a = ADDR_W'({$urandom, $urandom});
        if (op == OP_FREE && k < 92) begin
            pg = $urandom_range(0, total - 1);
            if (pg + cnt > total) cnt = COUNT_W'(total - pg);
            if (cnt == 0) cnt = COUNT_W'(1);
            a = page_addr(pg) | ADDR_W'($urandom_range(0, (1 << PSHIFT) - 1));
        end
        send_request(op, cnt, a, 1'b0, none, gaps);
    endtask

    req_row_t dir_rows[$];

    function automatic req_row_t row(input logic op, input int cnt,
                                     input logic [ADDR_W-1:0] a, input bit known,
                                     input logic [STATUS_W-1:0] st,
                                     input logic [ADDR_W-1:0] ra);
        req_row_t x;
        x.op = op;
        x.count = COUNT_W'(cnt);
        x.addr = a;
        x.known = known;
        x.res.status = st;
        x.res.addr = ra;
        return x;
    endfunction

    initial begin
        alloc_result_t none;
        none = '0;
        page_used = '0;
        next_fit = '0;
        cfg_total = 13'd4096;
        cfg_base = '0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table after reset: total 4096, base 0
        dir_rows.push_back(row(OP_ALLOC, 0, '0, 1, ST_INVALID, '0));
        dir_rows.push_back(row(OP_FREE, 0, '0, 1, ST_INVALID, '0));
        dir_rows.push_back(row(OP_ALLOC, 4097, '0, 1, ST_INVALID, '0));
        dir_rows.push_back(row(OP_ALLOC, 1, 48'hFFFF_FFFF_FFFF, 1, ST_OK, 48'h0));
        dir_rows.push_back(row(OP_ALLOC, 3, '0, 1, ST_OK, 48'h1000));
        dir_rows.push_back(row(OP_ALLOC, 4096, '0, 1, ST_NO_RUN, '0));
        dir_rows.push_back(row(OP_FREE, 2, 48'h2000, 1, ST_OK, '0));
        dir_rows.push_back(row(OP_FREE, 8, 48'hFFFF_FFFF_FFFF, 1, ST_INVALID, '0));
        dir_rows.push_back(row(OP_FREE, 8191, 48'h0, 1, ST_INVALID, '0));
        dir_rows.push_back(row(OP_ALLOC, 4092, '0, 0, ST_OK, '0));
        dir_rows.push_back(row(OP_ALLOC, 2, '0, 0, ST_OK, '0));
        dir_rows.push_back(row(OP_FREE, 4096, 48'h0, 1, ST_OK, '0));
        dir_rows.push_back(row(OP_ALLOC, 4096, '0, 1, ST_OK, 48'h0));
        dir_rows.push_back(row(OP_FREE, 4096, 48'h0, 1, ST_OK, '0));
        foreach (dir_rows[i])
            send_request(dir_rows[i].op, dir_rows[i].count, dir_rows[i].addr,
                         dir_rows[i].known, dir_rows[i].res, 1'b1);
        idle_input();
        drain();

        // scan wrap: fill the tail so no run can cross the end
        write_reg(REG_TOTAL_PAGES, 36'd100);
        send_request(OP_ALLOC, 90, '0, 1'b0, none, 1'b1);
        send_request(OP_FREE, 10, page_addr(0), 1'b0, none, 1'b1);
        send_request(OP_ALLOC, 8, '0, 1'b0, none, 1'b1);
        send_request(OP_ALLOC, 15, '0, 1'b0, none, 1'b1);
        idle_input();
        drain();

        // stale search position after lowering the size, then zero pages
        write_reg(REG_TOTAL_PAGES, 36'd20);
        send_request(OP_ALLOC, 2, '0, 1'b0, none, 1'b1);
        idle_input();
        drain();
        write_reg(REG_TOTAL_PAGES, 36'd0);
        send_request(OP_ALLOC, 1, '0, 1'b1, '{ST_INVALID, '0}, 1'b1);
        send_request(OP_FREE, 1, '0, 1'b1, '{ST_INVALID, '0}, 1'b1);
        idle_input();
        drain();

        // address overflow and free below base with the largest base
        write_reg(REG_TOTAL_PAGES, 36'd8191);
        write_reg(REG_BASE_FRAME, 36'hF_FFFF_FFFF);
        send_request(OP_FREE, 4096, page_addr(0), 1'b0, none, 1'b1);
        send_request(OP_ALLOC, 4, '0, 1'b0, none, 1'b1);
        send_request(OP_FREE, 1, 48'h0, 1'b1, '{ST_INVALID, '0}, 1'b1);
        idle_input();
        drain();

        // random phases across several settings
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_TOTAL_PAGES, 36'd4096);
                    write_reg(REG_BASE_FRAME, 36'd0);
                end
                1: begin
                    write_reg(REG_TOTAL_PAGES, 36'd64);
                    write_reg(REG_BASE_FRAME, FRAME_W'({$urandom, $urandom}));
                end
                2: begin
                    write_reg(REG_TOTAL_PAGES, 36'd1);
                    write_reg(REG_BASE_FRAME, 36'h0_0000_1234);
                end
                3: begin
                    write_reg(REG_TOTAL_PAGES, 36'($urandom_range(100, 600)));
                    write_reg(REG_BASE_FRAME, 36'hF_FFFF_FF00);
                end
                default: begin
                    write_reg(REG_TOTAL_PAGES, 36'd4096);
                    write_reg(REG_BASE_FRAME, FRAME_W'({$urandom, $urandom}));
                end
            endcase
            for (int n = 0; n < N_RANDOM / 5; n++) begin
                if (ph == 1 && n == 20) rx_hold = 200;
                if (n == 150) begin
                    // sender pause until everything has come back
                    idle_input();
                    while (pending_results.size() != 0) @(posedge aclk);
                end
                random_request(n % 97 < 80);
            end
            idle_input();
            drain();
        end

        if (errors == 0) begin
            $display("bitmap_page_allocator verification clean");
        end else begin
            $display("bitmap_page_allocator verification failed");
        end
        $finish;
    end

endmodule

FILE: files.f
design/bpa_pkg.sv
design/bpa_ram.sv
design/bpa_word_scan.sv
design/bitmap_page_allocator.sv
dv/tb_bitmap_page_allocator.sv
